FILE: src/tksk_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score keeper package
// Shared widths, codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package tksk_pkg;

    localparam int K_MAX_DEF  = 8;
    localparam int CNT_W      = 4;
    localparam int SCORE_W    = 32;
    localparam int MOVE_W     = 10;
    localparam int CHILD_W    = 10;
    localparam int FUNC_W     = 2;
    localparam int RSLOT_W    = 3;
    localparam int WSLOT_W    = 3;
    localparam int MIN_SLOT_W = 4;

    localparam logic signed [SCORE_W-1:0]    SCORE_TOP     = 32'sh7FFF_FFFF;
    localparam logic signed [MIN_SLOT_W-1:0] MIN_SLOT_NONE = 4'sb1111;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SCAN_END,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_need;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

FILE: src/tksk_ctrl.sv
// ----------------------------------------------------------------------------
// Top-k score keeper controller
// Sequences request capture, execution, minimum rescan and result hand-off.
// ----------------------------------------------------------------------------
module tksk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tksk_pkg::status_t status,
    output tksk_pkg::cmd_t    cmd
);
    import tksk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = status.scan_need ? S_SCAN : S_FINISH;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            S_SCAN_END:
            begin
                cmd = '0;
            end
            S_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/tksk_datapath.sv
// ----------------------------------------------------------------------------
// Top-k score keeper datapath
// Slot memory, table state, single-comparator minimum rescan, result register.
// ----------------------------------------------------------------------------
module tksk_datapath #(
    parameter int K_MAX = tksk_pkg::K_MAX_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  tksk_pkg::cmd_t                           cmd,
    output tksk_pkg::status_t                        status,
    input  logic                                     cfg_we,
    input  logic [tksk_pkg::CNT_W-1:0]               cfg_wdata,
    input  logic [tksk_pkg::FUNC_W-1:0]              func,
    input  logic signed [tksk_pkg::SCORE_W-1:0]      score,
    input  logic [tksk_pkg::MOVE_W-1:0]              move,
    input  logic signed [tksk_pkg::CHILD_W-1:0]      child_index,
    input  logic [tksk_pkg::RSLOT_W-1:0]             read_slot,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     accepted,
    output logic [tksk_pkg::WSLOT_W-1:0]             written_slot,
    output logic [tksk_pkg::CNT_W-1:0]               entry_count,
    output logic signed [tksk_pkg::SCORE_W-1:0]      min_score,
    output logic signed [tksk_pkg::MIN_SLOT_W-1:0]   min_slot,
    output logic signed [tksk_pkg::SCORE_W-1:0]      read_score,
    output logic [tksk_pkg::MOVE_W-1:0]              read_move,
    output logic signed [tksk_pkg::CHILD_W-1:0]      read_index
);
    import tksk_pkg::*;

    localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    // slot memory
    logic signed [SCORE_W-1:0] mem_score [K_MAX];
    logic [MOVE_W-1:0]         mem_move  [K_MAX];
    logic signed [CHILD_W-1:0] mem_child [K_MAX];

    logic                      mem_we;
    logic [SLOT_W-1:0]         wr_addr;
    logic [SLOT_W-1:0]         rd_addr;
    logic signed [SCORE_W-1:0] rd_score_reg;
    logic [MOVE_W-1:0]         rd_move_reg;
    logic signed [CHILD_W-1:0] rd_child_reg;

    // captured request
    func_t                     func_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [MOVE_W-1:0]         move_reg;
    logic signed [CHILD_W-1:0] child_reg;
    logic [RSLOT_W-1:0]        rslot_reg;

    // table state
    logic [CNT_W-1:0]          keep_reg,      keep_next;
    logic [CNT_W-1:0]          occ_reg,       occ_next;
    logic signed [SCORE_W-1:0] low_score_reg, low_score_next;
    logic [SLOT_W-1:0]         low_slot_reg,  low_slot_next;
    logic                      low_none_reg,  low_none_next;

    // rescan
    logic [SLOT_W-1:0]         scan_idx_reg,  scan_idx_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]         cmp_idx_reg,   cmp_idx_next;

    // per-request results
    logic                      acc_reg,       acc_next;
    logic [SLOT_W-1:0]         wslot_reg,     wslot_next;
    logic                      hit_reg,       hit_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_acc_reg;
    logic [WSLOT_W-1:0]        out_wslot_reg;
    logic [CNT_W-1:0]          out_count_reg;
    logic signed [SCORE_W-1:0] out_min_score_reg;
    logic signed [MIN_SLOT_W-1:0] out_min_slot_reg;
    logic signed [SCORE_W-1:0] out_rd_score_reg;
    logic [MOVE_W-1:0]         out_rd_move_reg;
    logic signed [CHILD_W-1:0] out_rd_child_reg;

    logic [CNT_W-1:0]          size;
    logic                      full;
    logic                      exec_scan;

    always_comb
    begin
        if (keep_reg == '0)
        begin
            size = CNT_W'(1);
        end
        else if (int'(keep_reg) > K_MAX)
        begin
            size = CNT_W'(K_MAX);
        end
        else
        begin
            size = keep_reg;
        end
    end

    assign full      = (occ_reg >= size);
    assign exec_scan = (func_reg == FUNC_INSERT) && full && !low_none_reg
                       && (score_reg > low_score_reg);

    assign status.scan_need = exec_scan;
    assign status.scan_last = (CNT_W'(scan_idx_reg) == (size - CNT_W'(1)));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign rd_addr = cmd.scan_issue ? scan_idx_reg : SLOT_W'(rslot_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_score[wr_addr] <= score_reg;
            mem_move[wr_addr]  <= move_reg;
            mem_child[wr_addr] <= child_reg;
        end
        rd_score_reg <= mem_score[rd_addr];
        rd_move_reg  <= mem_move[rd_addr];
        rd_child_reg <= mem_child[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            score_reg <= score;
            move_reg  <= move;
            child_reg <= child_index;
            rslot_reg <= read_slot;
        end
    end

    always_comb
    begin
        keep_next      = keep_reg;
        occ_next       = occ_reg;
        low_score_next = low_score_reg;
        low_slot_next  = low_slot_reg;
        low_none_next  = low_none_reg;
        scan_idx_next  = scan_idx_reg;
        acc_next       = acc_reg;
        wslot_next     = wslot_reg;
        hit_next       = hit_reg;
        mem_we         = 1'b0;
        wr_addr        = SLOT_W'(occ_reg);

        if (cfg_we)
        begin
            keep_next      = cfg_wdata;
            occ_next       = '0;
            low_score_next = SCORE_TOP;
            low_slot_next  = '0;
            low_none_next  = 1'b1;
        end

        if (cmd.exec)
        begin
            acc_next   = 1'b0;
            wslot_next = '0;
            hit_next   = 1'b0;
            case (func_reg)
                FUNC_INSERT:
                begin
                    if (full)
                    begin
                        if (exec_scan)
                        begin
                            mem_we         = 1'b1;
                            wr_addr        = low_slot_reg;
                            acc_next       = 1'b1;
                            wslot_next     = low_slot_reg;
                            low_score_next = score_reg;
                            scan_idx_next  = '0;
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if ((occ_reg == '0) || (score_reg < low_score_reg))
                        begin
                            low_score_next = score_reg;
                            low_slot_next  = SLOT_W'(occ_reg);
                            low_none_next  = 1'b0;
                        end
                        occ_next   = occ_reg + CNT_W'(1);
                        acc_next   = 1'b1;
                        wslot_next = SLOT_W'(occ_reg);
                    end
                end
                FUNC_CLEAR:
                begin
                    occ_next       = '0;
                    low_score_next = SCORE_TOP;
                    low_slot_next  = '0;
                    low_none_next  = 1'b1;
                end
                FUNC_READ:
                begin
                    hit_next = (int'(rslot_reg) < K_MAX)
                               && (CNT_W'(rslot_reg) < occ_reg);
                end
                default:
                begin
                    hit_next = 1'b0;
                end
            endcase
        end

        if (cmd.scan_issue)
        begin
            scan_idx_next = scan_idx_reg + SLOT_W'(1);
        end

        // strict compare keeps the current lowest slot on a tie
        if (cmp_valid_reg && (rd_score_reg < low_score_reg))
        begin
            low_score_next = rd_score_reg;
            low_slot_next  = cmp_idx_reg;
        end
    end

    assign cmp_valid_next = cmd.scan_issue;
    assign cmp_idx_next   = scan_idx_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= CNT_W'(K_MAX);
            occ_reg       <= '0;
            low_score_reg <= SCORE_TOP;
            low_slot_reg  <= '0;
            low_none_reg  <= 1'b1;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            acc_reg       <= 1'b0;
            wslot_reg     <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            keep_reg      <= keep_next;
            occ_reg       <= occ_next;
            low_score_reg <= low_score_next;
            low_slot_reg  <= low_slot_next;
            low_none_reg  <= low_none_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            acc_reg       <= acc_next;
            wslot_reg     <= wslot_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_acc_reg       <= acc_reg;
            out_wslot_reg     <= WSLOT_W'(wslot_reg);
            out_count_reg     <= occ_reg;
            out_min_score_reg <= low_score_reg;
            out_min_slot_reg  <= low_none_reg ? MIN_SLOT_NONE : MIN_SLOT_W'(low_slot_reg);
            out_rd_score_reg  <= hit_reg ? rd_score_reg : '0;
            out_rd_move_reg   <= hit_reg ? rd_move_reg  : '0;
            out_rd_child_reg  <= hit_reg ? rd_child_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = out_acc_reg;
    assign written_slot = out_wslot_reg;
    assign entry_count  = out_count_reg;
    assign min_score    = out_min_score_reg;
    assign min_slot     = out_min_slot_reg;
    assign read_score   = out_rd_score_reg;
    assign read_move    = out_rd_move_reg;
    assign read_index   = out_rd_child_reg;

endmodule

FILE: src/top_k_score_keeper_core.sv
// ----------------------------------------------------------------------------
// Top-k score keeper core
// Keeps the best scored candidates; insert, clear and slot read requests.
//
//   port group   direction   handshake          contents
//   in_*         input       in_valid/in_ready  func, score, move, child_index,
//                                               read_slot
//   out_*        output      out_valid/out_ready accepted, written_slot,
//                                               entry_count, min_score, min_slot,
//                                               read_score, read_move, read_index
//   cfg_*        input       cfg_we             keep_count
//
// One request at a time; accept, execute, then hand to the result register.
// Clear, read, appending or dropped insert: execute, then straight to finish.
// Insert replacing the minimum of a full table: a rescan of the effective keep
// count (1 to K_MAX) of slots by the single comparator walking the slot memory
// one read per cycle, before the result goes to the result register.
// Reset empties the table; keep_count returns to the table depth.
// A stalled result holds the request path in its final state until taken.
// ----------------------------------------------------------------------------
module top_k_score_keeper_core #(
    parameter int K_MAX = tksk_pkg::K_MAX_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [tksk_pkg::CNT_W-1:0]               cfg_wdata,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [tksk_pkg::FUNC_W-1:0]              func,
    input  logic signed [tksk_pkg::SCORE_W-1:0]      score,
    input  logic [tksk_pkg::MOVE_W-1:0]              move,
    input  logic signed [tksk_pkg::CHILD_W-1:0]      child_index,
    input  logic [tksk_pkg::RSLOT_W-1:0]             read_slot,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     accepted,
    output logic [tksk_pkg::WSLOT_W-1:0]             written_slot,
    output logic [tksk_pkg::CNT_W-1:0]               entry_count,
    output logic signed [tksk_pkg::SCORE_W-1:0]      min_score,
    output logic signed [tksk_pkg::MIN_SLOT_W-1:0]   min_slot,
    output logic signed [tksk_pkg::SCORE_W-1:0]      read_score,
    output logic [tksk_pkg::MOVE_W-1:0]              read_move,
    output logic signed [tksk_pkg::CHILD_W-1:0]      read_index
);
    import tksk_pkg::*;

    cmd_t    cmd;
    status_t status;

    tksk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tksk_datapath #(
        .K_MAX (K_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .func         (func),
        .score        (score),
        .move         (move),
        .child_index  (child_index),
        .read_slot    (read_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .written_slot (written_slot),
        .entry_count  (entry_count),
        .min_score    (min_score),
        .min_slot     (min_slot),
        .read_score   (read_score),
        .read_move    (read_move),
        .read_index   (read_index)
    );

endmodule

FILE: src/tksk_checker.sv
// ----------------------------------------------------------------------------
// Top-k score keeper checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module tksk_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic                                   accepted,
    input logic [tksk_pkg::WSLOT_W-1:0]           written_slot,
    input logic [tksk_pkg::CNT_W-1:0]             entry_count,
    input logic signed [tksk_pkg::SCORE_W-1:0]    min_score,
    input logic signed [tksk_pkg::MIN_SLOT_W-1:0] min_slot
);
    import tksk_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_score)
        && $stable(entry_count) && $stable(written_slot))
        else $error("result changed while stalled");

    // one request in flight
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((min_slot == MIN_SLOT_NONE) == (entry_count == '0)))
        else $error("minimum slot disagrees with entry count");

    a_empty_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (min_slot == MIN_SLOT_NONE) |-> (min_score == SCORE_TOP))
        else $error("empty table reports a minimum score");

    a_accept_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> (entry_count != '0))
        else $error("accepted insert left the table empty");

endmodule

bind top_k_score_keeper_core tksk_checker u_tksk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .written_slot (written_slot),
    .entry_count  (entry_count),
    .min_score    (min_score),
    .min_slot     (min_slot)
);

FILE: verif/top_k_score_keeper_core_tb.sv
// ----------------------------------------------------------------------------
// Top-k score keeper core testbench
// Sends insert, clear, read and unused-code requests through the valid/ready
// input, predicts every result from a local copy of the kept table and
// compares each result field by field. The keep count is rewritten between
// phases while the core is idle, from zero up to fifteen. Both sides idle at
// random except in every fourth phase. Two phases hold the result side off long.
// ----------------------------------------------------------------------------
module top_k_score_keeper_core_tb;

    import tksk_pkg::*;

    localparam int K_DEPTH        = K_MAX_DEF;
    localparam int PHASES         = 16;
    localparam int HALF_PHASE     = 45;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]         op;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic signed [CHILD_W-1:0] child;
        logic [RSLOT_W-1:0]        slot;
    } request_t;

    typedef struct {
        logic                         accepted;
        logic [WSLOT_W-1:0]           written_slot;
        logic [CNT_W-1:0]             entry_count;
        logic signed [SCORE_W-1:0]    min_score;
        logic signed [MIN_SLOT_W-1:0] min_slot;
        logic signed [SCORE_W-1:0]    read_score;
        logic [MOVE_W-1:0]            read_move;
        logic signed [CHILD_W-1:0]    read_index;
    } outcome_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_we      = 1'b0;
    logic [CNT_W-1:0]             cfg_wdata   = '0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic [FUNC_W-1:0]            func        = '0;
    logic signed [SCORE_W-1:0]    score       = '0;
    logic [MOVE_W-1:0]            move        = '0;
    logic signed [CHILD_W-1:0]    child_index = '0;
    logic [RSLOT_W-1:0]           read_slot   = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic                         accepted;
    logic [WSLOT_W-1:0]           written_slot;
    logic [CNT_W-1:0]             entry_count;
    logic signed [SCORE_W-1:0]    min_score;
    logic signed [MIN_SLOT_W-1:0] min_slot;
    logic signed [SCORE_W-1:0]    read_score;
    logic [MOVE_W-1:0]            read_move;
    logic signed [CHILD_W-1:0]    read_index;

    // kept table as predicted
    logic signed [SCORE_W-1:0] slot_score_mem [K_DEPTH];
    logic [MOVE_W-1:0]         slot_move_mem  [K_DEPTH];
    logic signed [CHILD_W-1:0] slot_child_mem [K_DEPTH];
    int unsigned               kept_entries = 0;
    logic signed [SCORE_W-1:0] lowest_kept  = SCORE_TOP;
    int                        lowest_at    = -1;
    logic [CNT_W-1:0]          keep_setting = 4'd8;

    request_t    pending_requests [$];
    outcome_t    expected_outcomes [$];
    request_t    offered;
    request_t    next_req;
    outcome_t    predicted;
    outcome_t    got;
    outcome_t    want;

    int unsigned requests_pushed  = 0;
    int unsigned requests_taken   = 0;
    int unsigned results_checked  = 0;
    int unsigned error_count      = 0;
    int unsigned appends          = 0;
    int unsigned replacements     = 0;
    int unsigned drops            = 0;
    int unsigned occupied_reads   = 0;
    int unsigned clears           = 0;
    int unsigned settings_written = 0;

    bit          sender_idling    = 1'b1;
    bit          receiver_idling  = 1'b1;
    int unsigned send_gap         = 0;
    int unsigned ready_gap        = 0;
    int unsigned hold_ticket      = 0;
    int unsigned hold_seen        = 0;
    int unsigned hold_left        = 0;
    int unsigned idle_cycles      = 0;

    top_k_score_keeper_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .score        (score),
        .move         (move),
        .child_index  (child_index),
        .read_slot    (read_slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .written_slot (written_slot),
        .entry_count  (entry_count),
        .min_score    (min_score),
        .min_slot     (min_slot),
        .read_score   (read_score),
        .read_move    (read_move),
        .read_index   (read_index)
    );

    always #5 clk = ~clk;

    function automatic void empty_kept_table();
        kept_entries = 0;
        lowest_kept  = SCORE_TOP;
        lowest_at    = -1;
    endfunction

    function automatic outcome_t predict_outcome(input request_t r);
        outcome_t    o;
        int unsigned size;
        int unsigned s;
        int          i;
        o = '{default: '0};
        size = (keep_setting == 0) ? 1 : ((keep_setting > K_DEPTH) ? K_DEPTH : keep_setting);
        case (r.op)
            FUNC_INSERT:
            begin
                if (kept_entries >= size) begin
                    if (r.score > lowest_kept && lowest_at >= 0) begin
                        s = unsigned'(lowest_at);
                        slot_score_mem[s] = r.score;
                        slot_move_mem[s]  = r.move;
                        slot_child_mem[s] = r.child;
                        o.accepted     = 1'b1;
                        o.written_slot = s[WSLOT_W-1:0];
                        lowest_kept    = r.score;
                        for (i = 0; i < size; i++) begin
                            if (slot_score_mem[i] < lowest_kept) begin
                                lowest_kept = slot_score_mem[i];
                                lowest_at   = i;
                            end
                        end
                        replacements++;
                    end
                    else begin
                        drops++;
                    end
                end
                else begin
                    s = kept_entries;
                    if (kept_entries == 0 || r.score < lowest_kept) begin
                        lowest_kept = r.score;
                        lowest_at   = int'(s);
                    end
                    slot_score_mem[s] = r.score;
                    slot_move_mem[s]  = r.move;
                    slot_child_mem[s] = r.child;
                    kept_entries++;
                    o.accepted     = 1'b1;
                    o.written_slot = s[WSLOT_W-1:0];
                    appends++;
                end
            end
            FUNC_CLEAR:
            begin
                empty_kept_table();
                clears++;
            end
            FUNC_READ:
            begin
                if (r.slot < kept_entries) begin
                    o.read_score = slot_score_mem[r.slot];
                    o.read_move  = slot_move_mem[r.slot];
                    o.read_index = slot_child_mem[r.slot];
                    occupied_reads++;
                end
            end
            default:
            begin
            end
        endcase
        o.entry_count = kept_entries[CNT_W-1:0];
        o.min_score   = lowest_kept;
        o.min_slot    = lowest_at[MIN_SLOT_W-1:0];
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic request_t random_request();
        request_t    r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            r.op = FUNC_INSERT;
        else if (pick < 88)
            r.op = FUNC_READ;
        else if (pick < 95)
            r.op = FUNC_CLEAR;
        else
            r.op = FUNC_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.score = SCORE_W'($urandom_range(0, 6) - 3);
        else if (pick < 40)
            case ($urandom_range(0, 3))
                0:       r.score = SCORE_TOP;
                1:       r.score = 32'sh8000_0000;
                2:       r.score = 32'sh8000_0001;
                default: r.score = 32'sh7FFF_FFFE;
            endcase
        else
            r.score = $urandom;
        r.move  = MOVE_W'($urandom_range(0, 1023));
        r.child = CHILD_W'($urandom_range(0, 512) - 1);
        r.slot  = RSLOT_W'($urandom_range(0, 7));
        return r;
    endfunction

    function automatic void add_pending(input request_t r);
        pending_requests = {pending_requests, r};
        requests_pushed++;
    endfunction

    function automatic void push_request(input logic [FUNC_W-1:0] f,
                                         input logic signed [SCORE_W-1:0] sc,
                                         input logic [MOVE_W-1:0] mv,
                                         input logic signed [CHILD_W-1:0] ch,
                                         input logic [RSLOT_W-1:0] rs);
        request_t r;
        r.op    = f;
        r.score = sc;
        r.move  = mv;
        r.child = ch;
        r.slot  = rs;
        add_pending(r);
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function automatic string outcome_text(input outcome_t o);
        return $sformatf("acc=%0d wslot=%0d cnt=%0d min=%0d@%0d rd=%0d/%0d/%0d",
                         o.accepted, o.written_slot, o.entry_count, o.min_score,
                         o.min_slot, o.read_score, o.read_move, o.read_index);
    endfunction

    task automatic write_keep_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        keep_setting = value;
        empty_kept_table();
        settings_written++;
    endtask

    task automatic wait_until_drained();
        while (requests_taken != requests_pushed || expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!(in_valid && !in_ready)) begin
            if (in_valid) begin
                offered.op    = func;
                offered.score = score;
                offered.move  = move;
                offered.child = child_index;
                offered.slot  = read_slot;
                predicted = predict_outcome(offered);
                expected_outcomes = {expected_outcomes, predicted};
                requests_taken++;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0) begin
                next_req = pending_requests.pop_front();
                func        <= next_req.op;
                score       <= next_req.score;
                move        <= next_req.move;
                child_index <= next_req.child;
                read_slot   <= next_req.slot;
                in_valid    <= 1'b1;
                send_gap    <= sender_idling ? pick_gap() : 0;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                results_checked++;
                got.accepted     = accepted;
                got.written_slot = written_slot;
                got.entry_count  = entry_count;
                got.min_score    = min_score;
                got.min_slot     = min_slot;
                got.read_score   = read_score;
                got.read_move    = read_move;
                got.read_index   = read_index;
                if (expected_outcomes.size() == 0) begin
                    note_failure({"result with nothing expected: ", outcome_text(got)});
                end
                else begin
                    want = expected_outcomes.pop_front();
                    if (got.accepted !== want.accepted || got.written_slot !== want.written_slot
                        || got.entry_count !== want.entry_count
                        || got.min_score !== want.min_score || got.min_slot !== want.min_slot
                        || got.read_score !== want.read_score
                        || got.read_move !== want.read_move
                        || got.read_index !== want.read_index)
                        note_failure($sformatf("result %0d expected %s got %s", results_checked,
                                               outcome_text(want), outcome_text(got)));
                end
            end
            if (hold_ticket != hold_seen) begin
                hold_seen <= hold_ticket;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (!receiver_idling) begin
                out_ready <= 1'b1;
            end
            else if (ready_gap != 0) begin
                ready_gap <= ready_gap - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    ready_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("top_k_score_keeper_core regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [CNT_W-1:0] keep_plan [PHASES];
        int unsigned      ph;
        int unsigned      n;
        keep_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd9, 4'd2,
                      4'd12, 4'd7, 4'd4, 4'd6, 4'd10, 4'd11, 4'd13, 4'd14};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // fill every slot before any read
        push_request(FUNC_INSERT, SCORE_TOP, 10'd1023, -10'sd1, 3'd0);
        push_request(FUNC_INSERT, 32'sh8000_0000, 10'd0, 10'sd511, 3'd7);
        push_request(FUNC_INSERT, 32'sh8000_0000, 10'h2AA, 10'sh155, 3'd0);
        push_request(FUNC_INSERT, 32'sd0, 10'h155, 10'sd0, 3'd0);
        push_request(FUNC_INSERT, 32'sh0001_8000, 10'd5, 10'sd3, 3'd0);
        push_request(FUNC_INSERT, -32'sd7, 10'd6, -10'sd1, 3'd0);
        push_request(FUNC_INSERT, 32'sh0064_0000, 10'd7, 10'sd7, 3'd0);
        push_request(FUNC_INSERT, -32'sd7, 10'd8, 10'sd8, 3'd0);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd0);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd7);
        push_request(FUNC_INSERT, 32'sh8000_0000, 10'd9, 10'sd9, 3'd0);
        push_request(FUNC_INSERT, 32'sh8000_0001, 10'd10, 10'sd10, 3'd0);
        push_request(FUNC_INSERT, -32'sd7, 10'd11, 10'sd11, 3'd0);
        push_request(FUNC_INSERT, -32'sd7, 10'd12, -10'sd1, 3'd0);
        push_request(FUNC_INSERT, -32'sd7, 10'd13, 10'sd13, 3'd0);
        push_request(FUNC_INSERT, SCORE_TOP, 10'd14, 10'sd14, 3'd0);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd1);
        push_request(FUNC_UNUSED, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd5);
        push_request(FUNC_CLEAR, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd2);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd0);
        push_request(FUNC_INSERT, 32'sd5, 10'd15, 10'sd15, 3'd0);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd0);
        push_request(FUNC_READ, $urandom, MOVE_W'($urandom), CHILD_W'($urandom), 3'd3);
        wait_until_drained();

        for (ph = 0; ph < PHASES; ph++) begin
            write_keep_count(keep_plan[ph]);
            sender_idling   = (ph % 4 != 2);
            receiver_idling = (ph % 4 != 2);
            for (n = 0; n < HALF_PHASE; n++)
                add_pending(random_request());
            if (ph == 3 || ph == 11)
                hold_ticket++;
            // hold the sender until every result is back
            wait_until_drained();
            for (n = 0; n < HALF_PHASE; n++)
                add_pending(random_request());
            wait_until_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d keep-count settings: %0d appends, %0d replacements,",
                 requests_taken, settings_written + 1, appends, replacements);
        $display("  %0d dropped inserts, %0d clears, %0d reads of kept slots, %0d results checked",
                 drops, clears, occupied_reads, results_checked);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("top_k_score_keeper_core regression: pass");
        else
            $display("top_k_score_keeper_core regression: fail");
        $finish;
    end

endmodule
